/* rtl/bdse_pkg.sv */
// Shared types and constants for the Brownian drive with stall escape.
// Used by the config register file, the controller and the datapath.
package bdse_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int MOTOR_FULL_DEF = 1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED         = 3'd0,
        CFG_NOISE_SCALE   = 3'd1,
        CFG_TURN_SCALE    = 3'd2,
        CFG_ESCAPE_ENABLE = 3'd3,
        CFG_ESCAPE_TICKS  = 3'd4,
        CFG_STILL_LIMIT   = 3'd5,
        CFG_GYRO_LIMIT    = 3'd6,
        CFG_ACCEL_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] speed;
        logic [14:0] noise_scale;
        logic [15:0] turn_scale;
        logic        escape_enable;
        logic [11:0] escape_ticks;
        logic [7:0]  still_limit;
        logic [14:0] gyro_limit;
        logic [14:0] accel_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        speed:         16'd9830,
        noise_scale:   15'd7080,
        turn_scale:    16'd8602,
        escape_enable: 1'b1,
        escape_ticks:  12'd48,
        still_limit:   8'd4,
        gyro_limit:    15'd474,
        accel_limit:   15'd461
    };

    // datapath step strobes from the controller
    typedef struct packed {
        logic load_in;
        logic prod;
        logic wrap;
        logic turn;
        logic diff;
        logic drive;
        logic load_out;
    } t_cmd;

    // heading wrap limits, Q3.13
    localparam logic signed [17:0] PI_Q     = 18'sd25736;
    localparam logic signed [17:0] NEG_PI_Q = -18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;

    // ceil(2^23 / 10): exact x/10 for x below 2^22
    localparam logic [19:0] RECIP10_Q  = 20'd838861;
    localparam int          RECIP10_SH = 23;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

endpackage

/* rtl/bdse_cfg.sv */
// Configuration register file for the Brownian drive block.
// Depends on bdse_pkg for the register layout and reset values.
module bdse_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdse_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdse_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bdse_pkg::t_cfg                      o_cfg
);
    import bdse_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_cfg_idx w_idx;

    assign w_idx = t_cfg_idx'(i_cfg_idx);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (w_idx)
                CFG_SPEED:         n_cfg.speed         = i_cfg_data;
                CFG_NOISE_SCALE:   n_cfg.noise_scale   = i_cfg_data[14:0];
                CFG_TURN_SCALE:    n_cfg.turn_scale    = i_cfg_data;
                CFG_ESCAPE_ENABLE: n_cfg.escape_enable = i_cfg_data[0];
                CFG_ESCAPE_TICKS:  n_cfg.escape_ticks  = i_cfg_data[11:0];
                CFG_STILL_LIMIT:   n_cfg.still_limit   = i_cfg_data[7:0];
                CFG_GYRO_LIMIT:    n_cfg.gyro_limit    = i_cfg_data[14:0];
                CFG_ACCEL_LIMIT:   n_cfg.accel_limit   = i_cfg_data[14:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/bdse_ctrl.sv */
// Sequencing controller: input/output handshakes and datapath step strobes.
// Depends on bdse_pkg for the command struct.
module bdse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bdse_pkg::t_cmd o_cmd
);
    import bdse_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_WRAP,
        ST_TURN,
        ST_DIFF,
        ST_DRIVE,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_PROD;
                end
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = ST_WRAP;
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = ST_TURN;
            end
            ST_TURN: begin
                o_cmd.turn = 1'b1;
                n_state    = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_DRIVE;
            end
            ST_DRIVE: begin
                o_cmd.drive = 1'b1;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/bdse_dp.sv */
// Datapath: stall detection, escape state, heading walk and wheel drive.
// Depends on bdse_pkg; steps are strobed by bdse_ctrl.
module bdse_dp #(
    parameter int MOTOR_FULL = bdse_pkg::MOTOR_FULL_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdse_pkg::t_cfg      i_cfg,
    input  bdse_pkg::t_cmd      i_cmd,
    input  logic signed [15:0]  i_gyro_x,
    input  logic signed [15:0]  i_gyro_y,
    input  logic signed [15:0]  i_gyro_z,
    input  logic signed [15:0]  i_accel_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    input  logic signed [15:0]  i_gauss_sample,
    input  logic                i_coin_bit,
    output logic [9:0]          o_left_drive,
    output logic [9:0]          o_right_drive,
    output logic                o_reverse_motors,
    output logic                o_escaping,
    output logic signed [15:0]  o_heading_out
);
    import bdse_pkg::*;

    localparam int MFW = $clog2(MOTOR_FULL + 1);
    localparam int PW  = 16 + MFW;
    localparam int SW  = (PW + 1 > 25) ? PW + 1 : 25;

    function automatic logic [15:0] mag16(input logic signed [15:0] x);
        logic [15:0] m;
        m = x[15] ? 16'(-x) : 16'(x);
        return m;
    endfunction

    function automatic logic signed [17:0] wrap1(input logic signed [17:0] h);
        logic signed [17:0] r;
        if (h <= NEG_PI_Q) begin
            r = h + TWO_PI_Q;
        end else if (h > PI_Q) begin
            r = h - TWO_PI_Q;
        end else begin
            r = h;
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp_u(input logic signed [17:0] u);
        logic [15:0] r;
        if (u < 18'sd0) begin
            r = 16'd0;
        end else if (u > $signed({2'b00, ONE_Q15})) begin
            r = ONE_Q15;
        end else begin
            r = u[15:0];
        end
        return r;
    endfunction

    // item registers
    logic signed [15:0] r_gyro [3];
    logic signed [15:0] r_accel [3];
    logic signed [15:0] r_gauss;
    logic               r_coin;

    // persistent state
    logic signed [15:0] r_heading;
    logic [7:0]         r_still;
    logic               r_in_escape;
    logic [11:0]        r_remaining;
    logic               r_spin_pos;

    // working registers
    logic signed [31:0] r_p_noise;
    logic [39:0]        r_p_mag;
    logic               r_use_esc;
    logic signed [17:0] r_dtheta;
    logic signed [34:0] r_p_turn;
    logic signed [17:0] r_diff;
    logic [PW-1:0]      r_prod_l;
    logic [PW-1:0]      r_prod_r;

    // output registers
    logic [9:0]         r_left;
    logic [9:0]         r_right;
    logic               r_escaping;
    logic signed [15:0] r_heading_out;

    // stall and escape update
    logic        w_moving;
    logic [7:0]  w_still_inc;
    logic        n_mid_esc;
    logic [7:0]  n_still;
    logic [11:0] n_remaining;
    logic        n_spin_pos;
    logic        n_in_escape;
    logic [11:0] w_rem_dec;
    logic [19:0] w_mag_x;

    always_comb begin
        w_moving = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (mag16(r_gyro[k]) > {1'b0, i_cfg.gyro_limit}) begin
                w_moving = 1'b1;
            end
            if (mag16(r_accel[k]) > {1'b0, i_cfg.accel_limit}) begin
                w_moving = 1'b1;
            end
        end
    end

    always_comb begin
        w_still_inc = (r_still == 8'hFF) ? r_still : r_still + 8'd1;
        n_mid_esc   = r_in_escape;
        n_still     = r_still;
        n_remaining = r_remaining;
        n_spin_pos  = r_spin_pos;
        if (!r_in_escape) begin
            if (w_moving) begin
                n_still = 8'd0;
            end else if (w_still_inc >= i_cfg.still_limit && i_cfg.escape_enable) begin
                n_still     = 8'd0;
                n_mid_esc   = 1'b1;
                n_remaining = i_cfg.escape_ticks;
                n_spin_pos  = r_coin;
            end else begin
                n_still = w_still_inc;
            end
        end
        w_rem_dec   = (n_remaining == 12'd0) ? n_remaining : n_remaining - 12'd1;
        n_in_escape = 1'b0;
        if (n_mid_esc) begin
            n_remaining = w_rem_dec;
            n_in_escape = (w_rem_dec != 12'd0);
        end
    end

    assign w_mag_x = (20'(i_cfg.speed) << 3) + 20'(i_cfg.speed) + 20'd5;

    // heading step rounding and wrap
    logic [31:0]        w_pn_mag;
    logic [31:0]        w_pn_sum;
    logic signed [17:0] w_dth_pos;
    logic signed [17:0] w_dtheta;
    logic signed [17:0] w_h0;
    logic signed [17:0] w_h2;

    always_comb begin
        w_pn_mag  = r_p_noise[31] ? 32'(-r_p_noise) : 32'(r_p_noise);
        w_pn_sum  = w_pn_mag + 32'd8192;
        w_dth_pos = $signed({1'b0, w_pn_sum[30:14]});
        w_dtheta  = r_p_noise[31] ? -w_dth_pos : w_dth_pos;
        w_h0      = 18'(r_heading) + w_dtheta;
        w_h2      = wrap1(wrap1(w_h0));
    end

    // differential
    logic [34:0]        w_pt_mag;
    logic [34:0]        w_pt_sum;
    logic [28:0]        w_rd;
    logic [15:0]        w_turn_mag;
    logic [15:0]        w_esc_mag;
    logic [15:0]        w_dmag;
    logic               w_dneg;
    logic signed [17:0] w_diff;

    always_comb begin
        w_pt_mag   = r_p_turn[34] ? 35'(-r_p_turn) : 35'(r_p_turn);
        w_pt_sum   = w_pt_mag + 35'd32;
        w_rd       = w_pt_sum[34:6];
        w_turn_mag = (w_rd > {13'd0, i_cfg.speed}) ? i_cfg.speed : w_rd[15:0];
        w_esc_mag  = r_p_mag[RECIP10_SH+15:RECIP10_SH];
        if (r_use_esc) begin
            w_dmag = w_esc_mag;
            w_dneg = !r_spin_pos;
        end else begin
            w_dmag = w_turn_mag;
            w_dneg = r_p_turn[34];
        end
        w_diff = w_dneg ? -$signed({2'b00, w_dmag}) : $signed({2'b00, w_dmag});
    end

    // wheel drive
    logic signed [17:0] w_ul;
    logic signed [17:0] w_ur;
    logic [SW-1:0]      w_sum_l;
    logic [SW-1:0]      w_sum_r;

    assign w_ul    = $signed({2'b00, i_cfg.speed}) - r_diff;
    assign w_ur    = $signed({2'b00, i_cfg.speed}) + r_diff;
    assign w_sum_l = SW'(r_prod_l) + SW'(16384);
    assign w_sum_r = SW'(r_prod_r) + SW'(16384);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_gyro[0]  <= i_gyro_x;
            r_gyro[1]  <= i_gyro_y;
            r_gyro[2]  <= i_gyro_z;
            r_accel[0] <= i_accel_x;
            r_accel[1] <= i_accel_y;
            r_accel[2] <= i_accel_z;
            r_gauss    <= i_gauss_sample;
            r_coin     <= i_coin_bit;
        end
        if (i_cmd.prod) begin
            r_p_noise <= $signed({1'b0, i_cfg.noise_scale}) * r_gauss;
            r_p_mag   <= 40'(w_mag_x) * 40'(RECIP10_Q);
            r_use_esc <= n_mid_esc;
        end
        if (i_cmd.wrap) begin
            r_dtheta <= w_dtheta;
        end
        if (i_cmd.turn) begin
            r_p_turn <= $signed({1'b0, i_cfg.turn_scale}) * r_dtheta;
        end
        if (i_cmd.diff) begin
            r_diff <= w_diff;
        end
        if (i_cmd.drive) begin
            r_prod_l <= PW'(clamp_u(w_ul)) * PW'(MOTOR_FULL);
            r_prod_r <= PW'(clamp_u(w_ur)) * PW'(MOTOR_FULL);
        end
        if (i_cmd.load_out) begin
            r_left        <= w_sum_l[24:15];
            r_right       <= w_sum_r[24:15];
            r_escaping    <= r_in_escape;
            r_heading_out <= r_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading   <= '0;
            r_still     <= '0;
            r_in_escape <= 1'b0;
            r_remaining <= '0;
            r_spin_pos  <= 1'b1;
        end else begin
            if (i_cmd.prod) begin
                r_still     <= n_still;
                r_in_escape <= n_in_escape;
                r_remaining <= n_remaining;
                r_spin_pos  <= n_spin_pos;
            end
            if (i_cmd.wrap) begin
                r_heading <= w_h2[15:0];
            end
        end
    end

    assign o_left_drive     = r_left;
    assign o_right_drive    = r_right;
    assign o_reverse_motors = r_escaping;
    assign o_escaping       = r_escaping;
    assign o_heading_out    = r_heading_out;

endmodule

/* rtl/brownian_drive_with_stall_escape.sv */
// Top level of the Brownian differential drive with stall escape.
// Depends on bdse_pkg, bdse_cfg, bdse_ctrl and bdse_dp.
//
// One item per control tick: six IMU readings, a Gaussian sample and a coin
// bit in, one drive command out. An item is taken in the idle state, then
// passes six datapath steps (product, wrap, turn, differential, drive, output
// load), each holding one multiply or one rounding, wrap or clamp; the last
// step waits until the output register is free. The next item is taken in the
// cycle after the result is loaded, while that result waits in the output
// register. Registers are to be written only while the block is idle, which
// the block itself does not enforce; they reset to their documented defaults.
module brownian_drive_with_stall_escape #(
    parameter int MOTOR_FULL = bdse_pkg::MOTOR_FULL_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bdse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [15:0]               i_gyro_x,
    input  logic signed [15:0]               i_gyro_y,
    input  logic signed [15:0]               i_gyro_z,
    input  logic signed [15:0]               i_accel_x,
    input  logic signed [15:0]               i_accel_y,
    input  logic signed [15:0]               i_accel_z,
    input  logic signed [15:0]               i_gauss_sample,
    input  logic                             i_coin_bit,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [9:0]                       o_left_drive,
    output logic [9:0]                       o_right_drive,
    output logic                             o_reverse_motors,
    output logic                             o_escaping,
    output logic signed [15:0]               o_heading_out
);
    import bdse_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;

    bdse_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bdse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    bdse_dp #(
        .MOTOR_FULL (MOTOR_FULL)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .i_gyro_x         (i_gyro_x),
        .i_gyro_y         (i_gyro_y),
        .i_gyro_z         (i_gyro_z),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_gauss_sample   (i_gauss_sample),
        .i_coin_bit       (i_coin_bit),
        .o_left_drive     (o_left_drive),
        .o_right_drive    (o_right_drive),
        .o_reverse_motors (o_reverse_motors),
        .o_escaping       (o_escaping),
        .o_heading_out    (o_heading_out)
    );

endmodule
